/* design/hrlp_pkg.sv */
// Shared types and constants for the HTTP request line parser.
// Used by the front, queue and back parts and by the top level.
package hrlp_pkg;

	localparam int POSITION_BITS_DEF = 16;

	// Byte class codes produced by the front part
	typedef struct packed {
		logic is_cr;
		logic is_lf;
		logic is_sp;
		logic is_upper;
		logic is_alpha;
		logic is_digit;
		logic is_slash;
		logic is_dot;
		logic is_colon;
		logic is_minus;
		logic is_pct;
		logic is_qmark;
		logic is_plus;
		logic is_nul;
		logic is_bslash;
		logic is_h;
		logic is_t;
		logic is_p;
		logic is_nz_digit;
	} byte_class_t;

	typedef struct packed {
		logic [7:0]  data;
		byte_class_t cls;
	} class_word_t;

	localparam int CLASS_WORD_BITS = $bits(class_word_t);

	localparam logic [2:0] ST_MORE     = 3'd0;
	localparam logic [2:0] ST_DONE     = 3'd1;
	localparam logic [2:0] ST_BAD_METH = 3'd2;
	localparam logic [2:0] ST_BAD_REQ  = 3'd3;
	localparam logic [2:0] ST_BAD_09   = 3'd4;

	localparam logic [3:0] MK_NONE      = 4'd0;
	localparam logic [3:0] MK_REQ_START = 4'd1;
	localparam logic [3:0] MK_METH_END  = 4'd2;
	localparam logic [3:0] MK_SCH_START = 4'd3;
	localparam logic [3:0] MK_SCH_END   = 4'd4;
	localparam logic [3:0] MK_HOST_ST   = 4'd5;
	localparam logic [3:0] MK_HOST_END  = 4'd6;
	localparam logic [3:0] MK_HOST_URI  = 4'd7;
	localparam logic [3:0] MK_PORT_URI  = 4'd8;
	localparam logic [3:0] MK_URI_START = 4'd9;
	localparam logic [3:0] MK_URI_END   = 4'd10;
	localparam logic [3:0] MK_ARGS      = 4'd11;
	localparam logic [3:0] MK_EXTEN     = 4'd12;
	localparam logic [3:0] MK_PROTO     = 4'd13;
	localparam logic [3:0] MK_URI_REQ   = 4'd14;
	localparam logic [3:0] MK_REQ_END   = 4'd15;

	localparam logic [1:0] M_UNKNOWN = 2'd0;
	localparam logic [1:0] M_GET     = 2'd1;
	localparam logic [1:0] M_HEAD    = 2'd2;
	localparam logic [1:0] M_POST    = 2'd3;

	localparam logic [9:0] VER_MAX = 10'd999;

	// Classify one raw byte
	function automatic byte_class_t classify(input logic [7:0] c);
		byte_class_t r;
		logic [7:0]  l;
		l = c | 8'h20;
		r.is_cr       = (c == 8'h0D);
		r.is_lf       = (c == 8'h0A);
		r.is_sp       = (c == 8'h20);
		r.is_upper    = (c >= 8'h41) && (c <= 8'h5A);
		r.is_alpha    = (l >= 8'h61) && (l <= 8'h7A);
		r.is_digit    = (c >= 8'h30) && (c <= 8'h39);
		r.is_nz_digit = (c >= 8'h31) && (c <= 8'h39);
		r.is_slash    = (c == 8'h2F);
		r.is_dot      = (c == 8'h2E);
		r.is_colon    = (c == 8'h3A);
		r.is_minus    = (c == 8'h2D);
		r.is_pct      = (c == 8'h25);
		r.is_qmark    = (c == 8'h3F);
		r.is_plus     = (c == 8'h2B);
		r.is_nul      = (c == 8'h00);
		r.is_bslash   = (c == 8'h5C);
		r.is_h        = (c == 8'h48);
		r.is_t        = (c == 8'h54);
		r.is_p        = (c == 8'h50);
		return r;
	endfunction

endpackage

/* design/hrlp_front.sv */
// Front part: accepts raw bytes and attaches their character classes.
// Depends on hrlp_pkg.
module hrlp_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	output logic                  cw_valid,
	input  logic                  cw_stall,
	output hrlp_pkg::class_word_t cw
);

	logic                  valid_q;
	hrlp_pkg::class_word_t word_q;

	assign in_stall = valid_q && cw_stall;
	assign cw_valid = valid_q;
	assign cw       = word_q;

	// advance the classified word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!in_stall) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_q.data <= data_byte;
			word_q.cls  <= hrlp_pkg::classify(data_byte);
		end
	end

endmodule

/* design/hrlp_queue.sv */
// Two-entry word queue between front and back parts.
// Depends on hrlp_pkg.
module hrlp_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_stall,
	input  hrlp_pkg::class_word_t wr_word,
	output logic                  rd_valid,
	input  logic                  rd_stall,
	output hrlp_pkg::class_word_t rd_word
);

	hrlp_pkg::class_word_t mem_q [2];
	logic                  wp_q;
	logic                  rp_q;
	logic [1:0]            cnt_q;
	logic                  push;
	logic                  pop;

	assign wr_stall = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_word  = mem_q[rp_q];
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;

	// hold pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_word;
	end

endmodule

/* design/hrlp_back.sv */
// Back part: runs the request line state machine on classified words.
// Depends on hrlp_pkg.
module hrlp_back #(
	parameter int POSITION_BITS = hrlp_pkg::POSITION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  backslash_as_slash,
	input  logic                  cw_valid,
	output logic                  cw_stall,
	input  hrlp_pkg::class_word_t cw,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            status,
	output logic [3:0]            mark,
	output logic [15:0]           position,
	output logic [1:0]            method,
	output logic [9:0]            version_major,
	output logic [9:0]            version_minor,
	output logic                  flag_complex,
	output logic                  flag_quoted,
	output logic                  flag_plus,
	output logic                  flag_nul
);

	typedef enum logic [4:0] {
		PH_START, PH_METHOD, PH_SP_URI, PH_SCHEME, PH_SCH_SL, PH_SCH_SL2,
		PH_HOST, PH_PORT, PH_AFTER_SL, PH_CHECK, PH_URI, PH_V09, PH_H,
		PH_HT, PH_HTT, PH_HTTP, PH_MAJ1, PH_MAJ, PH_MIN1, PH_MIN, PH_ALMOST
	} phase_t;

	localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

	phase_t                   ph_q, ph_d;
	logic [POSITION_BITS-1:0] off_q, pos, off_d;
	logic [31:0]              let_q, let_d;
	logic [2:0]               len_q, len_d;
	logic [1:0]               meth_q, meth_d;
	logic [9:0]               maj_q, maj_d, min_q, min_d;
	logic [3:0]               fl_q, fl_d;
	logic                     cr_q, cr_d;
	logic [2:0]               st;
	logic [3:0]               mk;
	logic                     take;
	logic                     bs;
	logic [13:0]              dig_maj, dig_min;
	logic [3:0]               dval;
	hrlp_pkg::byte_class_t    k;
	logic                     valid_q;

	assign out_valid = valid_q;
	assign cw_stall  = valid_q && out_stall;
	assign take      = cw_valid && !cw_stall;
	assign k         = cw.cls;
	assign bs        = backslash_as_slash && k.is_bslash;
	assign pos       = (ph_q == PH_START) ? '0 : off_q;
	assign dval      = cw.data[3:0];
	assign dig_maj   = {4'd0, maj_q} * 14'd10 + {10'd0, dval};
	assign dig_min   = {4'd0, min_q} * 14'd10 + {10'd0, dval};

	// work out next state and result for one word
	always_comb begin
		ph_d = ph_q; let_d = let_q; len_d = len_q; meth_d = meth_q;
		maj_d = maj_q; min_d = min_q; fl_d = fl_q; cr_d = cr_q;
		st = hrlp_pkg::ST_MORE; mk = hrlp_pkg::MK_NONE;
		case (ph_q)
			PH_START: begin
				if (!(k.is_cr || k.is_lf)) begin
					if (!k.is_upper) st = hrlp_pkg::ST_BAD_METH;
					else begin
						let_d = {let_q[23:0], cw.data};
						len_d = (len_q < 3'd5) ? len_q + 3'd1 : len_q;
						mk = hrlp_pkg::MK_REQ_START; ph_d = PH_METHOD;
					end
				end
			end
			PH_METHOD: begin
				if (k.is_sp) begin
					if (len_q == 3'd3 && let_q[23:0] == 24'h474554)
						meth_d = hrlp_pkg::M_GET;
					else if (len_q == 3'd4 && let_q == 32'h48454144)
						meth_d = hrlp_pkg::M_HEAD;
					else if (len_q == 3'd4 && let_q == 32'h504F5354)
						meth_d = hrlp_pkg::M_POST;
					mk = hrlp_pkg::MK_METH_END; ph_d = PH_SP_URI;
				end else if (!k.is_upper) st = hrlp_pkg::ST_BAD_METH;
				else begin
					let_d = {let_q[23:0], cw.data};
					len_d = (len_q < 3'd5) ? len_q + 3'd1 : len_q;
				end
			end
			PH_SP_URI: begin
				if (k.is_alpha) begin mk = hrlp_pkg::MK_SCH_START; ph_d = PH_SCHEME; end
				else if (k.is_slash) begin mk = hrlp_pkg::MK_URI_START; ph_d = PH_AFTER_SL; end
				else if (!k.is_sp) st = hrlp_pkg::ST_BAD_REQ;
			end
			PH_SCHEME: begin
				if (!k.is_alpha) begin
					if (k.is_colon) begin mk = hrlp_pkg::MK_SCH_END; ph_d = PH_SCH_SL; end
					else st = hrlp_pkg::ST_BAD_REQ;
				end
			end
			PH_SCH_SL: begin
				if (k.is_slash) ph_d = PH_SCH_SL2; else st = hrlp_pkg::ST_BAD_REQ;
			end
			PH_SCH_SL2: begin
				if (k.is_slash) begin mk = hrlp_pkg::MK_HOST_ST; ph_d = PH_HOST; end
				else st = hrlp_pkg::ST_BAD_REQ;
			end
			PH_HOST: begin
				if (!(k.is_alpha || k.is_digit || k.is_dot || k.is_minus)) begin
					if (k.is_colon) begin mk = hrlp_pkg::MK_HOST_END; ph_d = PH_PORT; end
					else if (k.is_slash) begin
						mk = hrlp_pkg::MK_HOST_URI; ph_d = PH_AFTER_SL;
					end else st = hrlp_pkg::ST_BAD_REQ;
				end
			end
			PH_PORT: begin
				if (!k.is_digit) begin
					if (k.is_slash) begin mk = hrlp_pkg::MK_PORT_URI; ph_d = PH_AFTER_SL; end
					else st = hrlp_pkg::ST_BAD_REQ;
				end
			end
			PH_AFTER_SL, PH_CHECK, PH_URI: begin
				if (k.is_sp) begin mk = hrlp_pkg::MK_URI_END; ph_d = PH_V09; end
				else if (k.is_cr) begin
					mk = hrlp_pkg::MK_URI_END; min_d = 10'd9; cr_d = 1'b1; ph_d = PH_ALMOST;
				end else if (k.is_lf) begin
					mk = hrlp_pkg::MK_URI_REQ; min_d = 10'd9; st = hrlp_pkg::ST_DONE;
				end else if (ph_q == PH_AFTER_SL) begin
					if (k.is_dot || k.is_slash || bs) begin fl_d[0] = 1'b1; ph_d = PH_URI; end
					else if (k.is_pct) begin fl_d[1] = 1'b1; ph_d = PH_URI; end
					else if (k.is_qmark) begin mk = hrlp_pkg::MK_ARGS; ph_d = PH_URI; end
					else if (k.is_plus) fl_d[2] = 1'b1;
					else if (k.is_nul) fl_d[3] = 1'b1;
					else ph_d = PH_CHECK;
				end else if (ph_q == PH_CHECK) begin
					if (k.is_slash) ph_d = PH_AFTER_SL;
					else if (k.is_dot) mk = hrlp_pkg::MK_EXTEN;
					else if (bs) begin fl_d[0] = 1'b1; ph_d = PH_AFTER_SL; end
					else if (k.is_pct) begin fl_d[1] = 1'b1; ph_d = PH_URI; end
					else if (k.is_plus) fl_d[2] = 1'b1;
					else if (k.is_qmark) begin mk = hrlp_pkg::MK_ARGS; ph_d = PH_URI; end
					else if (k.is_nul) fl_d[3] = 1'b1;
				end else begin
					if (k.is_plus) fl_d[2] = 1'b1;
					else if (k.is_nul) fl_d[3] = 1'b1;
				end
			end
			PH_V09: begin
				if (k.is_cr) begin min_d = 10'd9; cr_d = 1'b1; ph_d = PH_ALMOST; end
				else if (k.is_lf) begin
					min_d = 10'd9; mk = hrlp_pkg::MK_REQ_END; st = hrlp_pkg::ST_DONE;
				end else if (k.is_h) begin mk = hrlp_pkg::MK_PROTO; ph_d = PH_H; end
				else if (!k.is_sp) st = hrlp_pkg::ST_BAD_REQ;
			end
			PH_H: if (k.is_t) ph_d = PH_HT; else st = hrlp_pkg::ST_BAD_REQ;
			PH_HT: if (k.is_t) ph_d = PH_HTT; else st = hrlp_pkg::ST_BAD_REQ;
			PH_HTT: if (k.is_p) ph_d = PH_HTTP; else st = hrlp_pkg::ST_BAD_REQ;
			PH_HTTP: if (k.is_slash) ph_d = PH_MAJ1; else st = hrlp_pkg::ST_BAD_REQ;
			PH_MAJ1: begin
				if (!k.is_nz_digit) st = hrlp_pkg::ST_BAD_REQ;
				else begin maj_d = {6'd0, dval}; ph_d = PH_MAJ; end
			end
			PH_MAJ: begin
				if (k.is_dot) ph_d = PH_MIN1;
				else if (!k.is_digit) st = hrlp_pkg::ST_BAD_REQ;
				else maj_d = (dig_maj > 14'd999) ? hrlp_pkg::VER_MAX : dig_maj[9:0];
			end
			PH_MIN1: begin
				if (!k.is_digit) st = hrlp_pkg::ST_BAD_REQ;
				else begin min_d = {6'd0, dval}; ph_d = PH_MIN; end
			end
			PH_MIN: begin
				if (k.is_cr) begin cr_d = 1'b1; ph_d = PH_ALMOST; end
				else if (k.is_lf) begin mk = hrlp_pkg::MK_REQ_END; st = hrlp_pkg::ST_DONE; end
				else if (!k.is_digit) st = hrlp_pkg::ST_BAD_REQ;
				else min_d = (dig_min > 14'd999) ? hrlp_pkg::VER_MAX : dig_min[9:0];
			end
			PH_ALMOST: begin
				if (k.is_lf) begin mk = hrlp_pkg::MK_REQ_END; st = hrlp_pkg::ST_DONE; end
				else st = hrlp_pkg::ST_BAD_REQ;
			end
			default: ;
		endcase
		if (st == hrlp_pkg::ST_DONE && maj_d == 10'd0 && min_d == 10'd9 &&
		    meth_d != hrlp_pkg::M_GET)
			st = hrlp_pkg::ST_BAD_09;
		off_d = (ph_d == PH_START) ? '0 :
			((pos < POS_MAX) ? pos + POSITION_BITS'(1) : POS_MAX);
	end

	// hold parse state and the result word; restart after any final status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_START; off_q <= '0; let_q <= '0; len_q <= '0;
			meth_q <= hrlp_pkg::M_UNKNOWN; maj_q <= '0; min_q <= '0;
			fl_q <= '0; cr_q <= 1'b0; valid_q <= 1'b0;
			status <= hrlp_pkg::ST_MORE; mark <= hrlp_pkg::MK_NONE; position <= '0;
			method <= hrlp_pkg::M_UNKNOWN; version_major <= '0; version_minor <= '0;
			flag_complex <= 1'b0; flag_quoted <= 1'b0; flag_plus <= 1'b0;
			flag_nul <= 1'b0;
		end else begin
			if (!cw_stall) valid_q <= cw_valid;
			if (take) begin
				if (st != hrlp_pkg::ST_MORE) begin
					ph_q <= PH_START; off_q <= '0; let_q <= '0; len_q <= '0;
					meth_q <= hrlp_pkg::M_UNKNOWN; maj_q <= '0; min_q <= '0;
					fl_q <= '0; cr_q <= 1'b0;
				end else begin
					ph_q <= ph_d; off_q <= off_d; let_q <= let_d; len_q <= len_d;
					meth_q <= meth_d; maj_q <= maj_d; min_q <= min_d;
					fl_q <= fl_d; cr_q <= cr_d;
				end
				status        <= st;
				mark          <= mk;
				position      <= 16'(pos);
				method        <= meth_d;
				version_major <= maj_d;
				version_minor <= min_d;
				flag_complex  <= fl_d[0];
				flag_quoted   <= fl_d[1];
				flag_plus     <= fl_d[2];
				flag_nul      <= fl_d[3];
			end
		end
	end

endmodule

/* design/http_request_line_parser_core.sv */
// HTTP request line parser: top level joining front, queue and back parts.
// Depends on hrlp_pkg, hrlp_front, hrlp_queue and hrlp_back.
//
// Usage: raw request line bytes enter on data_byte with in_valid; a word is
// taken at a clock edge where in_valid is high and in_stall is low. Every
// byte yields one result word on out_valid/out_stall carrying status, mark,
// position, method, version and URI flags.
// Path: a taken byte passes the classifier register, one queue entry and the
// state machine's result register before it is offered as a result.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds, the queue fills and
// then the input stalls; nothing is lost. Reset (arst_n low) empties every
// stage and returns the parser to the start phase; backslash_as_slash
// resets to 0 and is written by cfg_we with cfg_data. The user must write
// it only while the block idles; the block itself does not enforce this.
// After a final status (done or an error) the parser restarts by itself.
module http_request_line_parser_core #(
	parameter int POSITION_BITS = hrlp_pkg::POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  mark,
	output logic [15:0] position,
	output logic [1:0]  method,
	output logic [9:0]  version_major,
	output logic [9:0]  version_minor,
	output logic        flag_complex,
	output logic        flag_quoted,
	output logic        flag_plus,
	output logic        flag_nul
);

	logic                  bs_q;
	logic                  f_valid, f_stall, q_valid, q_stall;
	hrlp_pkg::class_word_t f_word, q_word;

	// hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= 1'b0;
		end else if (cfg_we) begin
			bs_q <= cfg_data;
		end
	end

	hrlp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.data_byte(data_byte), .cw_valid(f_valid), .cw_stall(f_stall), .cw(f_word)
	);

	hrlp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(f_valid), .wr_stall(f_stall),
		.wr_word(f_word), .rd_valid(q_valid), .rd_stall(q_stall), .rd_word(q_word)
	);

	hrlp_back #(.POSITION_BITS(POSITION_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .backslash_as_slash(bs_q),
		.cw_valid(q_valid), .cw_stall(q_stall), .cw(q_word),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .mark(mark), .position(position), .method(method),
		.version_major(version_major), .version_minor(version_minor),
		.flag_complex(flag_complex), .flag_quoted(flag_quoted),
		.flag_plus(flag_plus), .flag_nul(flag_nul)
	);

endmodule
